### hdl/ccu_pkg.sv
// Shared types and constants for the comparator channel untangle unit.
// Field widths, configuration register indexes, map write and swap records.
// No dependencies.
package ccu_pkg;

	localparam int unsigned CH_W    = 5;
	localparam int unsigned LAYER_W = 8;
	localparam int unsigned CFG_W   = 5;
	localparam int unsigned CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_SECOND = 1'd1;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] SWAP_FIRST_RST  = 5'd0;
	localparam logic [CFG_W-1:0] SWAP_SECOND_RST = 5'd1;

	typedef logic [CH_W-1:0]    chan_t;
	typedef logic [LAYER_W-1:0] layer_t;

	// one write into the channel map, addressed by channel number
	typedef struct packed {
		logic  en;
		chan_t ch;
		chan_t val;
	} map_wr_t;

	// channel pair exchanged in the map when a network starts
	typedef struct packed {
		logic  en;
		chan_t first;
		chan_t second;
	} swap_t;

	// true when the channel has a map entry
	function automatic logic ch_in_range(chan_t ch, int unsigned channels);
		return int'(ch) < int'(channels);
	endfunction

endpackage

### hdl/ccu_bank.sv
// One bank of the channel map: synchronous memory, one write port,
// two read ports with registered read data. Depends on ccu_pkg.
module ccu_bank import ccu_pkg::*; #(
	parameter int unsigned CHANNELS = 32
) (
	input  logic    clk,
	input  map_wr_t wr,
	input  logic    rd_en,
	input  chan_t   rd_ch_a,
	input  chan_t   rd_ch_b,
	output chan_t   rd_data_a,
	output chan_t   rd_data_b
);

	localparam int unsigned IDX_W = $clog2(CHANNELS);

	chan_t mem [CHANNELS];

	// map a channel onto an entry address, out-of-range channels to entry zero
	function automatic logic [IDX_W-1:0] to_idx(chan_t ch);
		logic [IDX_W+CH_W-1:0] wide;
		wide = {{IDX_W{1'b0}}, ch};
		if (ch_in_range(ch, CHANNELS))
			return wide[IDX_W-1:0];
		return '0;
	endfunction

	// write port
	always_ff @(posedge clk) begin
		if (wr.en)
			mem[to_idx(wr.ch)] <= wr.val;
	end

	// read ports, data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[to_idx(rd_ch_a)];
			rd_data_b <= mem[to_idx(rd_ch_b)];
		end
	end

endmodule

### hdl/ccu_lookup.sv
// Map lookup for the untangle unit: per-entry valid and bank select bits,
// the latched swap pair, and forwarding of the last write. Depends on ccu_pkg.
module ccu_lookup import ccu_pkg::*; #(
	parameter int unsigned CHANNELS = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  logic    start,
	input  chan_t   ch_a,
	input  chan_t   ch_b,
	input  chan_t   bank0_a,
	input  chan_t   bank0_b,
	input  chan_t   bank1_a,
	input  chan_t   bank1_b,
	input  chan_t   cfg_first,
	input  chan_t   cfg_second,
	input  map_wr_t wr0,
	input  map_wr_t wr1,
	output chan_t   map_a,
	output chan_t   map_b
);

	localparam int unsigned IDX_W = $clog2(CHANNELS);

	logic [CHANNELS-1:0] valid_q;
	logic [CHANNELS-1:0] sel_q;
	logic [CHANNELS-1:0] valid_d;
	logic [CHANNELS-1:0] sel_d;
	swap_t               swap_q;
	swap_t               swap_cfg;
	map_wr_t             fwd0_q;
	map_wr_t             fwd1_q;

	function automatic logic [IDX_W-1:0] to_idx(chan_t ch);
		logic [IDX_W+CH_W-1:0] wide;
		wide = {{IDX_W{1'b0}}, ch};
		return wide[IDX_W-1:0];
	endfunction

	// value of an entry not written since the network started
	function automatic chan_t base_val(swap_t sw, chan_t ch);
		if (sw.en && ch == sw.first)
			return sw.second;
		if (sw.en && ch == sw.second)
			return sw.first;
		return ch;
	endfunction

	// resolve one channel: range, fresh network, forwarded write, bank, base
	function automatic chan_t resolve(chan_t ch, chan_t d0, chan_t d1,
			logic strt, swap_t sw_new, swap_t sw_old, map_wr_t f0, map_wr_t f1,
			logic [CHANNELS-1:0] vld, logic [CHANNELS-1:0] sel);
		logic [IDX_W-1:0] idx;
		idx = to_idx(ch);
		if (!ch_in_range(ch, CHANNELS))
			return ch;
		if (strt)
			return base_val(sw_new, ch);
		if (f0.en && f0.ch == ch)
			return f0.val;
		if (f1.en && f1.ch == ch)
			return f1.val;
		if (vld[idx])
			return sel[idx] ? d1 : d0;
		return base_val(sw_old, ch);
	endfunction

	// swap pair taken from the registers at a start
	always_comb begin
		swap_cfg.first  = cfg_first;
		swap_cfg.second = cfg_second;
		swap_cfg.en     = (cfg_first != cfg_second) && ch_in_range(cfg_first, CHANNELS)
			&& ch_in_range(cfg_second, CHANNELS);
	end

	assign map_a = resolve(ch_a, bank0_a, bank1_a, start, swap_cfg, swap_q,
		fwd0_q, fwd1_q, valid_q, sel_q);
	assign map_b = resolve(ch_b, bank0_b, bank1_b, start, swap_cfg, swap_q,
		fwd0_q, fwd1_q, valid_q, sel_q);

	// next valid and bank select bits: drop all at a start, mark written entries
	always_comb begin
		valid_d = start ? '0 : valid_q;
		sel_d   = sel_q;
		if (wr0.en) begin
			valid_d[to_idx(wr0.ch)] = 1'b1;
			sel_d[to_idx(wr0.ch)]   = 1'b0;
		end
		if (wr1.en) begin
			valid_d[to_idx(wr1.ch)] = 1'b1;
			sel_d[to_idx(wr1.ch)]   = 1'b1;
		end
	end

	// advance tracking state on each processed comparator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			sel_q   <= '0;
			swap_q  <= '0;
			fwd0_q  <= '0;
			fwd1_q  <= '0;
		end else if (fire) begin
			valid_q <= valid_d;
			sel_q   <= sel_d;
			fwd0_q  <= wr0;
			fwd1_q  <= wr1;
			if (start)
				swap_q <= swap_cfg;
		end
	end

endmodule

### hdl/comparator_channel_untangle_unit.sv
// Top level of the comparator channel untangle unit: stream ports,
// configuration registers, compare stage and output register.
// Depends on ccu_pkg, ccu_bank and ccu_lookup.
//
//  channel   dir  tdata (low bit up)                        tuser
//  s_*       in   layer_in, from_channel, to_channel        start_network
//  m_*       out  layer_out, low_channel, high_channel      -
//  cfg_*     in   swap_first, swap_second by cfg_idx        -
//
// One comparator per cycle sustained while m_* does not stall; each result passes
// the map bank read, then lookup, compare and write back, then the output register.
// Forwarding of the previous write covers the read that overlaps it.
// Reset clears the valid bits at once, so the map reads as the identity
// with no clearing pass. A stall on m_* holds the output and lookup stages.
module comparator_channel_untangle_unit import ccu_pkg::*; #(
	parameter int unsigned CHANNELS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // layer_in, from_channel, to_channel, zero pad
	input  logic                 s_tuser,   // start_network
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // layer_out, low_channel, high_channel, zero pad
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic    [CFG_W-1:0] swap_first_q;
	logic    [CFG_W-1:0] swap_second_q;
	logic    in_xfer;
	logic    s1_fire;
	logic    valid_s1;
	logic    start_s1;
	layer_t  layer_s1;
	chan_t   from_s1;
	chan_t   to_s1;
	layer_t  in_layer;
	chan_t   in_from;
	chan_t   in_to;
	chan_t   b0_a, b0_b, b1_a, b1_b;
	chan_t   map_lo;
	chan_t   map_hi;
	logic    turn;
	map_wr_t wr0;
	map_wr_t wr1;
	logic    out_valid_q;
	layer_t  out_layer_q;
	chan_t   out_low_q;
	chan_t   out_high_q;

	assign in_layer = s_tdata[7:0];
	assign in_from  = s_tdata[12:8];
	assign in_to    = s_tdata[17:13];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_first_q  <= SWAP_FIRST_RST;
			swap_second_q <= SWAP_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SWAP_FIRST:  swap_first_q  <= cfg_wdata;
				REG_SWAP_SECOND: swap_second_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake: lookup stage moves when the output register is free or drains
	assign s1_fire  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_fire;
	assign in_xfer  = s_tvalid && s_tready;

	// hold the accepted comparator while its map entries are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			start_s1 <= s_tuser;
			layer_s1 <= in_layer;
			from_s1  <= in_from;
			to_s1    <= in_to;
		end
	end

	ccu_bank #(.CHANNELS(CHANNELS)) u_bank0 (
		.clk       (clk),
		.wr        (wr0),
		.rd_en     (in_xfer),
		.rd_ch_a   (in_from),
		.rd_ch_b   (in_to),
		.rd_data_a (b0_a),
		.rd_data_b (b0_b)
	);

	ccu_bank #(.CHANNELS(CHANNELS)) u_bank1 (
		.clk       (clk),
		.wr        (wr1),
		.rd_en     (in_xfer),
		.rd_ch_a   (in_from),
		.rd_ch_b   (in_to),
		.rd_data_a (b1_a),
		.rd_data_b (b1_b)
	);

	ccu_lookup #(.CHANNELS(CHANNELS)) u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_fire),
		.start      (start_s1),
		.ch_a       (from_s1),
		.ch_b       (to_s1),
		.bank0_a    (b0_a),
		.bank0_b    (b0_b),
		.bank1_a    (b1_a),
		.bank1_b    (b1_b),
		.cfg_first  (swap_first_q),
		.cfg_second (swap_second_q),
		.wr0        (wr0),
		.wr1        (wr1),
		.map_a      (map_lo),
		.map_b      (map_hi)
	);

	// turn the comparator around and exchange the two original entries
	always_comb begin
		turn       = map_lo > map_hi;
		wr0.en     = s1_fire && turn && ch_in_range(from_s1, CHANNELS);
		wr0.ch     = from_s1;
		wr0.val    = map_hi;
		wr1.en     = s1_fire && turn && ch_in_range(to_s1, CHANNELS);
		wr1.ch     = to_s1;
		wr1.val    = map_lo;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_fire)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_layer_q <= layer_s1;
			out_low_q   <= turn ? map_hi : map_lo;
			out_high_q  <= turn ? map_lo : map_hi;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_high_q, out_low_q, out_layer_q};

`ifndef SYNTHESIS
	// emitted comparators are always normalized
	a_out_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_low_q <= out_high_q)
		else $error("output comparator not normalized");

	// the lookup stage never blocks the input when it is empty
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty lookup stage");

	// the two bank writes of one comparator never hit the same channel
	a_wr_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(wr0.en && wr1.en) |-> wr0.ch != wr1.ch)
		else $error("both map writes target one channel");

	// a write happens only for a comparator leaving the lookup stage
	a_wr_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(wr0.en || wr1.en) |-> s1_fire)
		else $error("map write without a processed comparator");
`endif

endmodule
